// File: rtl/core/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg: shared constants and types of the pulse period power meter
// Register indexes, reset values, item codes and the configuration bundle.
// ----------------------------------------------------------------------------
package ppm_pkg;

    localparam int DataW          = 32;
    localparam int ReadW          = 16;
    localparam int FuncW          = 2;
    localparam int CaptureW       = 16;
    localparam int TimerW         = 16;
    localparam int CfgIdxW        = 3;
    localparam int OvfW           = 2;
    localparam int CaptureBitsDef = 16;

    // register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] REG_POWER_SCALE   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_CURRENT_SCALE = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_VOLTAGE_SCALE = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_TICK_SCALE    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_TIMER_PERIOD  = 3'd4;

    // reset values
    localparam logic [DataW-1:0]  RST_POWER_SCALE   = 32'd1033921207;
    localparam logic [DataW-1:0]  RST_CURRENT_SCALE = 32'd1448450;
    localparam logic [DataW-1:0]  RST_VOLTAGE_SCALE = 32'd408462700;
    localparam logic [DataW-1:0]  RST_TICK_SCALE    = 32'd3125;
    localparam logic [TimerW-1:0] RST_TIMER_PERIOD  = 16'd65535;

    // item function codes
    localparam logic [FuncW-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FuncW-1:0] FUNC_POWER = 2'd1;
    localparam logic [FuncW-1:0] FUNC_MIXED = 2'd2;

    // which reading a capture updates
    localparam logic [1:0] TGT_POWER   = 2'd0;
    localparam logic [1:0] TGT_CURRENT = 2'd1;
    localparam logic [1:0] TGT_VOLTAGE = 2'd2;

    typedef struct packed {
        logic [DataW-1:0]  power_scale;
        logic [DataW-1:0]  current_scale;
        logic [DataW-1:0]  voltage_scale;
        logic [DataW-1:0]  tick_scale;
        logic [TimerW-1:0] timer_period;
    } t_cfg;

endpackage

// File: rtl/core/ppm_if.sv
// ----------------------------------------------------------------------------
// ppm_if: channel interfaces of the pulse period power meter
// Input item channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface ppm_in_if;
    logic                          valid;
    logic                          ready;
    logic [ppm_pkg::FuncW-1:0]     func;
    logic [ppm_pkg::CaptureW-1:0]  capture_value;

    modport source (output valid, output func, output capture_value, input ready);
    modport sink   (input valid, input func, input capture_value, output ready);
endinterface

interface ppm_out_if;
    logic                       valid;
    logic                       ready;
    logic [ppm_pkg::ReadW-1:0]  power_x10;
    logic [ppm_pkg::ReadW-1:0]  current_x10;
    logic [ppm_pkg::ReadW-1:0]  voltage_x10;
    logic                       select_voltage;

    modport source (output valid, output power_x10, output current_x10,
                    output voltage_x10, output select_voltage, input ready);
    modport sink   (input valid, input power_x10, input current_x10,
                    input voltage_x10, input select_voltage, output ready);
endinterface

interface ppm_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [ppm_pkg::CfgIdxW-1:0]  index;
    logic [ppm_pkg::DataW-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/ppm_cfg_regs.sv
// ----------------------------------------------------------------------------
// ppm_cfg_regs: configuration register file
// Five scale and timer registers written through the register channel.
// ----------------------------------------------------------------------------
module ppm_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ppm_cfg_if.sink        i_cfg,
    output ppm_pkg::t_cfg  o_cfg
);
    import ppm_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_scale   <= RST_POWER_SCALE;
            r_cfg.current_scale <= RST_CURRENT_SCALE;
            r_cfg.voltage_scale <= RST_VOLTAGE_SCALE;
            r_cfg.tick_scale    <= RST_TICK_SCALE;
            r_cfg.timer_period  <= RST_TIMER_PERIOD;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_POWER_SCALE:   r_cfg.power_scale   <= i_cfg.data;
                REG_CURRENT_SCALE: r_cfg.current_scale <= i_cfg.data;
                REG_VOLTAGE_SCALE: r_cfg.voltage_scale <= i_cfg.data;
                REG_TICK_SCALE:    r_cfg.tick_scale    <= i_cfg.data;
                REG_TIMER_PERIOD:  r_cfg.timer_period  <= i_cfg.data[TimerW-1:0];
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/core/ppm_div.sv
// ----------------------------------------------------------------------------
// ppm_div: iterative restoring divider
// One quotient bit per cycle; done pulses as the last quotient bit is registered.
// ----------------------------------------------------------------------------
module ppm_div #(
    parameter int W = ppm_pkg::DataW
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);
    import ppm_pkg::*;

    localparam int CntW = $clog2(W);

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [W-1:0]    r_rem;
    logic [W-1:0]    r_quo;
    logic [W-1:0]    r_dvs;

    logic [W:0]      trial;
    logic            fits;
    logic [W:0]      n_rem;

    // shift in next dividend bit, subtract when it fits
    assign trial = {r_rem, r_quo[W-1]};
    assign fits  = trial >= {1'b0, r_dvs};
    assign n_rem = fits ? (trial - {1'b0, r_dvs}) : trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem[W-1:0];
            r_quo <= {r_quo[W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/core/pulse_period_power_meter.sv
// ----------------------------------------------------------------------------
// pulse_period_power_meter: power, current and voltage from pulse periods
// Input beats are timer overflow ticks or captures on the power channel and
// on the current/voltage channel. Every beat gives one result beat with the
// three latest readings and the select line after that beat.
//
// Channels: i_in (func, capture_value), o_out (readings, select_voltage),
// i_cfg (register writes, always ready, write only while idle).
// Path: a tick's result beat goes from the finish state into the output
// register; a capture passes the multiply, the divider start, the quotient
// bits of the shared bit-serial divider, the quotient capture and the output
// register. A zero product skips the divider.
// Flow: one item at a time; i_in.ready is high only in the idle state, so
// the block takes no new beat until the last one has left the finish state.
// Reset: all counters, previous captures and readings clear to zero, the
// select line goes to current mode, registers take their default values.
// Stall: the result sits in an output register; a new beat is accepted while
// it waits, and its own result holds in the finish state until o_out frees.
// ----------------------------------------------------------------------------
module pulse_period_power_meter #(
    parameter int CAPTURE_BITS = ppm_pkg::CaptureBitsDef
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ppm_in_if.sink  i_in,
    ppm_out_if.source o_out,
    ppm_cfg_if.sink i_cfg
);
    import ppm_pkg::*;

    // only the low capture bits are kept
    localparam int CapW = (CAPTURE_BITS < CaptureW) ? CAPTURE_BITS : CaptureW;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_DIV_GO = 3'd2;
    localparam logic [2:0] ST_DIV_WT = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    t_cfg cfg;

    logic [2:0]       r_state;
    logic [CapW-1:0]  r_pwr_prev;
    logic [CapW-1:0]  r_mix_prev;
    logic [OvfW-1:0]  r_pwr_ovf;
    logic [OvfW-1:0]  r_mix_ovf;
    logic             r_sel;
    logic [ReadW-1:0] r_pwr_rd;
    logic [ReadW-1:0] r_cur_rd;
    logic [ReadW-1:0] r_vol_rd;
    logic [1:0]       r_target;
    logic [DataW-1:0] r_period;
    logic [DataW-1:0] r_prod;

    logic             r_out_valid;
    logic [ReadW-1:0] r_out_pwr;
    logic [ReadW-1:0] r_out_cur;
    logic [ReadW-1:0] r_out_vol;
    logic             r_out_sel;

    logic             in_beat;
    logic             is_pwr;
    logic [DataW-1:0] cap_ext;
    logic [DataW-1:0] prev_ext;
    logic [OvfW-1:0]  ovf_sel;
    logic [DataW-1:0] n_period;
    logic             div_start;
    logic             div_done;
    logic [DataW-1:0] div_quo;
    logic [DataW-1:0] dividend;
    logic [ReadW-1:0] half_q;
    logic [ReadW-1:0] pwr_x10;
    logic             out_free;

    ppm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_beat    = i_in.valid && i_in.ready;

    // period of the channel named by func, 32-bit wrapping
    assign is_pwr   = (i_in.func == FUNC_POWER);
    assign cap_ext  = DataW'(i_in.capture_value[CapW-1:0]);
    assign prev_ext = is_pwr ? DataW'(r_pwr_prev) : DataW'(r_mix_prev);
    assign ovf_sel  = is_pwr ? r_pwr_ovf : r_mix_ovf;

    always_comb begin
        if (ovf_sel >= 2'd2) begin
            n_period = '0;
        end else if (ovf_sel == 2'd1) begin
            n_period = DataW'(cfg.timer_period) - prev_ext + cap_ext;
        end else begin
            n_period = cap_ext - prev_ext;
        end
    end

    // dividend for the reading being refreshed
    always_comb begin
        case (r_target)
            TGT_POWER:   dividend = cfg.power_scale;
            TGT_CURRENT: dividend = cfg.current_scale;
            TGT_VOLTAGE: dividend = cfg.voltage_scale;
            default:     dividend = cfg.power_scale;
        endcase
    end

    assign div_start = (r_state == ST_DIV_GO) && (r_prod != '0);

    ppm_div #(
        .W (DataW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_prod),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // quotient halved, low 16 bits; power reading times ten by shift and add
    assign half_q  = div_quo[ReadW:1];
    assign pwr_x10 = {half_q[ReadW-4:0], 3'b000} + {half_q[ReadW-2:0], 1'b0};

    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pwr_prev <= '0;
            r_mix_prev <= '0;
            r_pwr_ovf  <= '0;
            r_mix_ovf  <= '0;
            r_sel      <= 1'b0;
            r_pwr_rd   <= '0;
            r_cur_rd   <= '0;
            r_vol_rd   <= '0;
            r_target   <= TGT_POWER;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        case (i_in.func)
                            FUNC_TICK: begin
                                // overflow counters saturate at two
                                if (r_pwr_ovf < 2'd2) r_pwr_ovf <= r_pwr_ovf + 2'd1;
                                if (r_mix_ovf < 2'd2) r_mix_ovf <= r_mix_ovf + 2'd1;
                                r_state <= ST_DONE;
                            end
                            FUNC_POWER: begin
                                r_pwr_ovf  <= '0;
                                r_pwr_prev <= i_in.capture_value[CapW-1:0];
                                r_target   <= TGT_POWER;
                                r_state    <= ST_MUL;
                            end
                            FUNC_MIXED: begin
                                r_mix_ovf  <= '0;
                                r_mix_prev <= i_in.capture_value[CapW-1:0];
                                r_target   <= r_sel ? TGT_VOLTAGE : TGT_CURRENT;
                                r_sel      <= !r_sel;
                                r_state    <= ST_MUL;
                            end
                            default: begin
                                // unused code: result repeats the readings
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    r_state <= ST_DIV_GO;
                end
                ST_DIV_GO: begin
                    if (r_prod == '0) begin
                        // zero product reads as zero
                        case (r_target)
                            TGT_POWER:   r_pwr_rd <= '0;
                            TGT_CURRENT: r_cur_rd <= '0;
                            default:     r_vol_rd <= '0;
                        endcase
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_DIV_WT;
                    end
                end
                ST_DIV_WT: begin
                    if (div_done) begin
                        case (r_target)
                            TGT_POWER:   r_pwr_rd <= pwr_x10;
                            TGT_CURRENT: r_cur_rd <= half_q;
                            default:     r_vol_rd <= half_q;
                        endcase
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // period capture and the registered multiply, low 32 bits
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_period <= n_period;
        end
        if (r_state == ST_MUL) begin
            r_prod <= DataW'(r_period * cfg.tick_scale);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_pwr <= r_pwr_rd;
            r_out_cur <= r_cur_rd;
            r_out_vol <= r_vol_rd;
            r_out_sel <= r_sel;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.power_x10      = r_out_pwr;
    assign o_out.current_x10    = r_out_cur;
    assign o_out.voltage_x10    = r_out_vol;
    assign o_out.select_voltage = r_out_sel;

endmodule

// File: tb/ppm_checker.sv
// ----------------------------------------------------------------------------
// ppm_checker: result prediction and comparison for the pulse period power meter
// Watches the input, result and register write channels, keeps its own copy
// of the meter state and registers, queues the expected readings of every
// accepted input beat and compares each result beat with the oldest one.
// ----------------------------------------------------------------------------
module ppm_checker #(
    parameter int CAPTURE_BITS = ppm_pkg::CaptureBitsDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ppm_in_if    i_in,
    ppm_out_if   i_out,
    ppm_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import ppm_pkg::*;

    localparam logic [OvfW-1:0] OvfMax = 2'd2;
    localparam logic [CaptureW-1:0] CapMask = (CAPTURE_BITS >= CaptureW) ?
        {CaptureW{1'b1}} : ({CaptureW{1'b1}} >> (CaptureW - CAPTURE_BITS));

    typedef struct packed {
        logic [ReadW-1:0] power_x10;
        logic [ReadW-1:0] current_x10;
        logic [ReadW-1:0] voltage_x10;
        logic             select_voltage;
    } t_readings;

    t_cfg                meter_cfg;
    logic [CaptureW-1:0] power_prev;
    logic [CaptureW-1:0] mixed_prev;
    logic [OvfW-1:0]     power_ovf;
    logic [OvfW-1:0]     mixed_ovf;
    logic                select_q;
    t_readings           latest;
    t_readings           readings_q[$];

    // period in 32-bit wrapping arithmetic
    function automatic logic [DataW-1:0] pulse_period(input logic [CaptureW-1:0] prev,
                                                      input logic [OvfW-1:0] ovf,
                                                      input logic [CaptureW-1:0] cap,
                                                      input logic [TimerW-1:0] reload);
        logic [DataW-1:0] p;
        logic [DataW-1:0] c;
        logic [DataW-1:0] r;
        p = prev;
        c = cap;
        r = reload;
        if (ovf >= OvfMax) begin
            return '0;
        end else if (ovf == 2'd1) begin
            return r - p + c;
        end
        return c - p;
    endfunction

    function automatic logic [DataW-1:0] scaled_value(input logic [DataW-1:0] dividend,
                                                      input logic [DataW-1:0] period,
                                                      input logic [DataW-1:0] tick);
        logic [DataW-1:0] prod;
        prod = period * tick;
        if (prod == '0) begin
            return '0;
        end
        return (dividend / prod) >> 1;
    endfunction

    task automatic check_field(input string name, input logic [ReadW-1:0] want,
                               input logic [ReadW-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_readings           got;
        t_readings           want;
        logic [CaptureW-1:0] cap;
        logic [DataW-1:0]    period;
        logic [DataW-1:0]    power_full;
        if (!i_rst_n) begin
            meter_cfg.power_scale   = RST_POWER_SCALE;
            meter_cfg.current_scale = RST_CURRENT_SCALE;
            meter_cfg.voltage_scale = RST_VOLTAGE_SCALE;
            meter_cfg.tick_scale    = RST_TICK_SCALE;
            meter_cfg.timer_period  = RST_TIMER_PERIOD;
            power_prev = '0;
            mixed_prev = '0;
            power_ovf  = '0;
            mixed_ovf  = '0;
            select_q   = 1'b0;
            latest     = '0;
            o_fail_count = 0;
            readings_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got.power_x10      = i_out.power_x10;
                got.current_x10    = i_out.current_x10;
                got.voltage_x10    = i_out.voltage_x10;
                got.select_voltage = i_out.select_voltage;
                if (readings_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, expected none actual %h",
                             $time, got);
                    o_fail_count++;
                end else begin
                    want = readings_q.pop_front();
                    check_field("power_x10", want.power_x10, got.power_x10);
                    check_field("current_x10", want.current_x10, got.current_x10);
                    check_field("voltage_x10", want.voltage_x10, got.voltage_x10);
                    check_field("select_voltage", ReadW'(want.select_voltage),
                                ReadW'(got.select_voltage));
                end
            end

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_POWER_SCALE:   meter_cfg.power_scale   = i_cfg.data;
                    REG_CURRENT_SCALE: meter_cfg.current_scale = i_cfg.data;
                    REG_VOLTAGE_SCALE: meter_cfg.voltage_scale = i_cfg.data;
                    REG_TICK_SCALE:    meter_cfg.tick_scale    = i_cfg.data;
                    REG_TIMER_PERIOD:  meter_cfg.timer_period  = i_cfg.data[TimerW-1:0];
                    default: ;
                endcase
            end

            if (i_in.valid && i_in.ready) begin
                cap = i_in.capture_value & CapMask;
                case (i_in.func)
                    FUNC_TICK: begin
                        if (power_ovf < OvfMax) power_ovf = power_ovf + 2'd1;
                        if (mixed_ovf < OvfMax) mixed_ovf = mixed_ovf + 2'd1;
                    end
                    FUNC_POWER: begin
                        period = pulse_period(power_prev, power_ovf, cap,
                                              meter_cfg.timer_period);
                        power_ovf  = '0;
                        power_prev = cap;
                        power_full = scaled_value(meter_cfg.power_scale, period,
                                                  meter_cfg.tick_scale) * 32'd10;
                        latest.power_x10 = power_full[ReadW-1:0];
                    end
                    FUNC_MIXED: begin
                        period = pulse_period(mixed_prev, mixed_ovf, cap,
                                              meter_cfg.timer_period);
                        mixed_ovf  = '0;
                        mixed_prev = cap;
                        if (!select_q) begin
                            power_full = scaled_value(meter_cfg.current_scale, period,
                                                      meter_cfg.tick_scale);
                            latest.current_x10 = power_full[ReadW-1:0];
                        end else begin
                            power_full = scaled_value(meter_cfg.voltage_scale, period,
                                                      meter_cfg.tick_scale);
                            latest.voltage_x10 = power_full[ReadW-1:0];
                        end
                        select_q = ~select_q;
                    end
                    default: ;
                endcase
                latest.select_voltage = select_q;
                readings_q.push_back(latest);
            end
        end
        o_pending = readings_q.size();
    end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the pulse period power meter
// Drives directed and random pulse trains (ticks, power and mixed captures)
// through several register settings, with random gaps on the input and
// random stalls on the result channel; the checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
    import ppm_pkg::*;

    // codes the package leaves unnamed
    localparam logic [FuncW-1:0]   FUNC_UNUSED = 2'd3;
    localparam logic [CfgIdxW-1:0] REG_UNUSED  = 3'd7;

    localparam int SettleCycles = 60;        // covers the capture latency
    localparam int TimeLimit    = 2_000_000; // far beyond the slowest correct run

    logic i_clk;
    logic i_rst_n;
    logic calm;                 // when high, neither side idles
    int   fail_count;
    int   pending;
    int   sent;                 // beats with a used func code
    logic [CaptureW-1:0] last_power_cap;
    logic [CaptureW-1:0] last_mixed_cap;

    ppm_in_if  in_ch ();
    ppm_out_if out_ch ();
    ppm_cfg_if cfg_ch ();

    pulse_period_power_meter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    ppm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // result side: stalls about one cycle in ten unless calm
    always @(negedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= 10);
    end

    // overall time limit
    initial begin
        #(TimeLimit);
        $display("FAIL");
        $finish;
    end

    // one input beat, with a random gap ahead of it
    task automatic send_item(input logic [FuncW-1:0] func, input logic [CaptureW-1:0] cap);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 10) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.func          <= func;
        in_ch.capture_value <= cap;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        // func 3 beats only repeat the readings, so they are not counted
        if (func != FUNC_UNUSED) sent++;
        if (func == FUNC_POWER) last_power_cap = cap;
        if (func == FUNC_MIXED) last_mixed_cap = cap;
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_config(input logic [DataW-1:0] power_scale,
                               input logic [DataW-1:0] current_scale,
                               input logic [DataW-1:0] voltage_scale,
                               input logic [DataW-1:0] tick_scale,
                               input logic [DataW-1:0] timer_period);
        write_reg(REG_POWER_SCALE, power_scale);
        write_reg(REG_CURRENT_SCALE, current_scale);
        write_reg(REG_VOLTAGE_SCALE, voltage_scale);
        write_reg(REG_TICK_SCALE, tick_scale);
        write_reg(REG_TIMER_PERIOD, timer_period);
    endtask

    // stop the input and wait until every expected result beat has come
    task automatic drain;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // mostly well-formed pulse trains: a few ticks, then a capture on one
    // channel; sometimes unused-code beats, tick bursts past saturation, or
    // captures below the previous one
    task automatic random_beats(input int count);
        int                  target;
        int                  r;
        int                  ticks;
        logic [FuncW-1:0]    func;
        logic [CaptureW-1:0] base;
        logic [CaptureW-1:0] cap;
        target = sent + count;
        while (sent < target) begin
            r = $urandom_range(99);
            if (r < 8) begin
                send_item(FUNC_UNUSED, CaptureW'($urandom));
            end else begin
                r = $urandom_range(99);
                if (r < 55)      ticks = 0;
                else if (r < 80) ticks = 1;
                else if (r < 92) ticks = 2;
                else             ticks = $urandom_range(3, 5);
                repeat (ticks) send_item(FUNC_TICK, CaptureW'($urandom));
                func = $urandom_range(1) ? FUNC_POWER : FUNC_MIXED;
                base = (func == FUNC_POWER) ? last_power_cap : last_mixed_cap;
                r = $urandom_range(99);
                if (r < 45)      cap = CaptureW'($urandom);
                else if (r < 75) cap = base + CaptureW'($urandom_range(1, 2000));
                else if (r < 85) cap = base - CaptureW'($urandom_range(1, 500));
                else if (r < 92) cap = $urandom_range(1) ? '1 : '0;
                else             cap = base;
                send_item(func, cap);
            end
        end
    endtask

    initial begin
        in_ch.valid         = 1'b0;
        in_ch.func          = FUNC_TICK;
        in_ch.capture_value = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_POWER_SCALE;
        cfg_ch.data         = '0;
        calm                = 1'b0;
        sent                = 0;
        last_power_cap      = '0;
        last_mixed_cap      = '0;
        i_rst_n             = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on the reset settings
        send_item(FUNC_POWER, 16'd0);        // zero period right after reset
        send_item(FUNC_MIXED, 16'd0);        // current slot, zero period
        send_item(FUNC_UNUSED, 16'hFFFF);    // unused code repeats readings
        send_item(FUNC_POWER, 16'd1000);     // plain difference
        send_item(FUNC_MIXED, 16'd500);      // voltage slot
        send_item(FUNC_MIXED, 16'd600);      // back to current
        send_item(FUNC_TICK, 16'hFFFF);      // one overflow
        send_item(FUNC_POWER, 16'd200);      // one-overflow period
        send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_TICK, 16'd0);         // counters saturate at two
        send_item(FUNC_POWER, 16'd300);      // two overflows give zero
        send_item(FUNC_MIXED, 16'd100);      // mixed channel saturated too
        send_item(FUNC_POWER, 16'd100);      // smaller capture, difference wraps
        send_item(FUNC_POWER, 16'hFFFF);     // largest capture
        send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_MIXED, 16'hFFFF);     // one overflow on the mixed channel
        send_item(FUNC_UNUSED, 16'd0);
        send_item(FUNC_POWER, 16'hFFFF);     // same capture after one overflow, full timer period
        send_item(FUNC_MIXED, 16'd0);        // wrap on the mixed channel
        random_beats(90);

        // largest dividends, unit tick scale, short timer period with junk
        // in the upper data bits
        drain();
        load_config('1, '1, '1, 32'd1, {16'hA5A5, 16'd100});
        send_item(FUNC_POWER, 16'd60000);
        send_item(FUNC_MIXED, 16'd65000);
        send_item(FUNC_TICK, 16'd0);
        send_item(FUNC_POWER, 16'd5);        // previous capture above timer period
        send_item(FUNC_MIXED, 16'd7);
        random_beats(90);

        // all zero: zero products everywhere, zero timer period
        drain();
        load_config('0, '0, '0, '0, 32'hFFFF_0000);
        random_beats(60);

        // largest tick scale, random dividends, no idling on either side
        drain();
        calm <= 1'b1;
        load_config($urandom, $urandom, $urandom, '1, 32'h0000_FFFF);
        random_beats(100);
        calm <= 1'b0;

        // random settings with a small tick scale, plus a write to no register
        drain();
        load_config($urandom, $urandom, $urandom, DataW'($urandom_range(1, 8)), $urandom);
        write_reg(REG_UNUSED, $urandom);
        random_beats(100);

        drain();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
